/* hdl/stx_frame_receiver_assert.svh */
// Assertion macros for the STX frame receiver.
`ifndef STX_FRAME_RECEIVER_ASSERT_SVH
`define STX_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, skipped while reset is high.
`define STX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stx_frame_receiver: assertion failed");

// Checked property, also during reset.
`define STX_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("stx_frame_receiver: assertion failed");

`else

`define STX_ASSERT(lbl, clk, rst, prop)
`define STX_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hdl/stx_pkg.sv */
// Shared types, constants and checksum function of the STX frame receiver.
`default_nettype none

package stx_pkg;

   localparam logic [7:0] BYTE_ACK   = 8'h06;
   localparam logic [7:0] BYTE_STX   = 8'h02;
   localparam logic [7:0] STX_SUBST  = 8'hFD;
   localparam logic [7:0] MIN_FRAME  = 8'd5;
   localparam logic [7:0] POS_NODE   = 8'd2;
   localparam logic [7:0] POS_TAG    = 8'd4;
   localparam logic [7:0] POS_LENGTH = 8'd1;
   localparam logic [7:0] POS_FIRST  = 8'd2;
   localparam logic [7:0] RESET_NODE = 8'h10;
   localparam logic [7:0] RESET_TAG  = 8'h80;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // register indexes
   localparam logic CSR_NODE = 1'b0;
   localparam logic CSR_TAG  = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_LEN,
      MODE_FRAME,
      MODE_ESC
   } mode_type;

   typedef enum logic [1:0] {
      OP_ACK,
      OP_START,
      OP_DATA,
      OP_ABORT
   } op_type;

   typedef enum logic [2:0] {
      EV_START = 3'd0,
      EV_BYTE  = 3'd1,
      EV_ACK   = 3'd2,
      EV_GOOD  = 3'd3,
      EV_BAD   = 3'd4,
      EV_ABORT = 3'd5
   } event_type;

   // classified word from front to back
   typedef struct packed {
      op_type     op;
      logic       last;
      logic [7:0] data;
      logic [7:0] pos;
      logic [7:0] len;
   } cmd_type;

   typedef struct packed {
      event_type  kind;
      logic [7:0] data;
      logic [7:0] pos;
      logic [7:0] len;
   } rsp_type;

   // rotate left, add byte, fold the carry back in
   function automatic logic [7:0] cks_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] rot;
      logic [8:0] sum;
      rot = {acc[6:0], acc[7]};
      sum = {1'b0, rot} + {1'b0, b};
      return sum[7:0] + {7'd0, sum[8]};
   endfunction

endpackage

`default_nettype wire

/* hdl/stx_fifo.sv */
// Small synchronous FIFO used between the receiver stages and at the output.
`default_nettype none

module stx_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

/* hdl/stx_front.sv */
// Front stage: tracks the framing mode and classifies each received byte.
`default_nettype none

module stx_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          take,
   input  wire logic [7:0]    rx_byte,
   output logic               cmd_push,
   output stx_pkg::cmd_type   cmd
);

   import stx_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] len_ff, len_in;
   logic       do_start, do_data, do_abort, do_ack;
   logic [7:0] data_val;
   logic       last;

   assign last = ({1'b0, count_ff} + 9'd1) >= {1'b0, len_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         len_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      len_in   = len_ff;
      do_start = 1'b0;
      do_data  = 1'b0;
      do_abort = 1'b0;
      do_ack   = 1'b0;
      data_val = rx_byte;

      if (take) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (rx_byte == BYTE_ACK) begin
                  do_ack = 1'b1;
               end else if (rx_byte == BYTE_STX) begin
                  mode_in = MODE_LEN;
               end
            end
            MODE_LEN: begin
               if (rx_byte < MIN_FRAME) begin
                  mode_in = MODE_IDLE;
               end else begin
                  do_start = 1'b1;
               end
            end
            MODE_FRAME: begin
               if (rx_byte == BYTE_STX) begin
                  mode_in = MODE_ESC;
               end else begin
                  do_data = 1'b1;
               end
            end
            MODE_ESC: begin
               if (rx_byte == 8'd0) begin
                  do_data  = 1'b1;
                  data_val = BYTE_STX;    // stuffed STX
               end else if (rx_byte >= MIN_FRAME) begin
                  do_start = 1'b1;        // restart
               end else begin
                  do_abort = 1'b1;
                  mode_in  = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end

      if (do_start) begin
         len_in   = rx_byte;
         count_in = POS_FIRST;
         mode_in  = MODE_FRAME;
      end
      if (do_data) begin
         if (last) begin
            mode_in = MODE_IDLE;
         end else begin
            mode_in  = MODE_FRAME;
            count_in = count_ff + 8'd1;
         end
      end

      cmd_push = do_start || do_data || do_abort || do_ack;
      cmd.last = last;
      cmd.data = data_val;
      cmd.pos  = count_ff;
      cmd.len  = len_ff;
      if (do_ack) begin
         cmd.op  = OP_ACK;
         cmd.pos = '0;
         cmd.len = '0;
      end else if (do_start) begin
         cmd.op  = OP_START;
         cmd.pos = POS_LENGTH;
         cmd.len = rx_byte;
      end else if (do_abort) begin
         cmd.op = OP_ABORT;
      end else begin
         cmd.op = OP_DATA;
      end
   end

endmodule

`default_nettype wire

/* hdl/stx_back.sv */
// Back stage: runs the checksum, captures node and tag, and builds result words.
`default_nettype none

module stx_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_empty,
   input  wire stx_pkg::cmd_type cmd,
   output logic               cmd_pop,
   input  wire logic          rsp_full,
   output logic               rsp_push,
   output stx_pkg::rsp_type   rsp,
   input  wire logic [7:0]    expected_node,
   input  wire logic [7:0]    expected_tag
);

   import stx_pkg::*;

   logic [7:0] cks_ff, cks_in;
   logic [7:0] node_ff, node_in;
   logic [7:0] tag_ff, tag_in;
   logic       go;
   logic [7:0] node_eff, tag_eff, fin;
   logic       good;

   assign go       = !cmd_empty && !rsp_full;
   assign cmd_pop  = go;
   assign rsp_push = go;

   assign node_eff = (cmd.pos == POS_NODE) ? cmd.data : node_ff;
   assign tag_eff  = (cmd.pos == POS_TAG) ? cmd.data : tag_ff;
   assign fin      = (cks_ff == BYTE_STX) ? STX_SUBST : cks_ff;
   assign good     = (cmd.data == fin) && (node_eff == expected_node)
                     && (tag_eff == expected_tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         cks_ff  <= '0;
         node_ff <= '0;
         tag_ff  <= '0;
      end else begin
         cks_ff  <= cks_in;
         node_ff <= node_in;
         tag_ff  <= tag_in;
      end
   end

   always_comb begin
      cks_in   = cks_ff;
      node_in  = node_ff;
      tag_in   = tag_ff;
      rsp.data = cmd.data;
      rsp.pos  = cmd.pos;
      rsp.len  = cmd.len;
      rsp.kind = EV_BYTE;

      unique case (cmd.op)
         OP_ACK: begin
            rsp.kind = EV_ACK;
         end
         OP_START: begin
            rsp.kind = EV_START;
            if (go) begin
               cks_in  = cks_step(cks_step(8'd0, BYTE_STX), cmd.data);
               node_in = '0;
               tag_in  = '0;
            end
         end
         OP_DATA: begin
            if (go) begin
               node_in = node_eff;
               tag_in  = tag_eff;
            end
            if (cmd.last) begin
               rsp.kind = good ? EV_GOOD : EV_BAD;
            end else begin
               rsp.kind = EV_BYTE;
               if (go) begin
                  cks_in = cks_step(cks_ff, cmd.data);
               end
            end
         end
         OP_ABORT: begin
            rsp.kind = EV_ABORT;
         end
         default: begin
            rsp.kind = EV_ABORT;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/stx_frame_receiver.sv */
// Top level of the STX frame receiver: front, command queue, back, result queue.
//
// Usage: received bytes go in on req_rx_byte, one word per cycle while
// req_push is high and req_full is low. Result words (start, frame byte,
// ack, good, bad, abort) are read from the rsp_ ports while rsp_empty is
// low and taken with rsp_pop. Bytes that cause no result (idle noise, an
// opening STX, a short length, a frame STX) are consumed silently.
// Throughput: one byte per cycle while req_full is low. A taken byte's
// result shows after both queues (front classifies into the command
// queue, back updates the checksum and writes the result queue).
// When the receiver stops popping, the result queue fills, the back stage
// stalls, the command queue fills and req_full rises; no word is lost.
// Reset (synchronous, active high) empties both queues, returns the framer
// to idle and loads expected node 0x10 and expected tag 0x80.
// Registers: csr_index 0 is the expected node, 1 the expected tag; the user
// must write them with csr_write_en while no frame is in flight; unchecked.
`default_nettype none

`include "stx_frame_receiver_assert.svh"

module stx_frame_receiver #(
   parameter int CMD_DEPTH = stx_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = stx_pkg::RSP_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic [7:0] req_rx_byte,
   output logic            req_full,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [2:0]      rsp_event_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [7:0]      rsp_byte_position,
   output logic [7:0]      rsp_frame_length,
   input  wire logic       csr_write_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   import stx_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [7:0] exp_node_ff, exp_tag_ff;
   logic       take;
   logic       f_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type    f_cmd, b_cmd;
   logic       rsp_push, rsp_full;
   rsp_type    b_rsp, out_rsp;
   logic       byte_pos_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_node_ff <= RESET_NODE;
         exp_tag_ff  <= RESET_TAG;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_NODE: exp_node_ff <= csr_wdata;
            CSR_TAG:  exp_tag_ff  <= csr_wdata;
            default:  exp_node_ff <= exp_node_ff;
         endcase
      end
   end

   assign take     = req_push && !cmd_full;
   assign req_full = cmd_full;

   stx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_rx_byte),
      .cmd_push (f_push),
      .cmd      (f_cmd)
   );

   stx_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (f_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (b_cmd),
      .empty (cmd_empty)
   );

   stx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (cmd_empty),
      .cmd           (b_cmd),
      .cmd_pop       (cmd_pop),
      .rsp_full      (rsp_full),
      .rsp_push      (rsp_push),
      .rsp           (b_rsp),
      .expected_node (exp_node_ff),
      .expected_tag  (exp_tag_ff)
   );

   stx_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (b_rsp),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (out_rsp),
      .empty (rsp_empty)
   );

   assign rsp_event_kind    = out_rsp.kind;
   assign rsp_data_byte     = out_rsp.data;
   assign rsp_byte_position = out_rsp.pos;
   assign rsp_frame_length  = out_rsp.len;

   // a plain frame byte lies after the length and before the checksum
   assign byte_pos_ok = (rsp_byte_position >= POS_FIRST)
                        && (({1'b0, rsp_byte_position} + 9'd1) < {1'b0, rsp_frame_length});

   // reset leaves both queues empty
   `STX_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> rsp_empty && !req_full)

   // only defined event codes leave the block
   `STX_ASSERT(a_kind_legal, clock, reset, !rsp_empty |-> rsp_event_kind <= EV_ABORT)

   `STX_ASSERT(a_byte_pos, clock, reset, (!rsp_empty && rsp_event_kind == EV_BYTE) |-> byte_pos_ok)

endmodule

`default_nettype wire

/* tb/stx_frame_receiver_tb.sv */
// Self-checking testbench for the STX frame receiver: random and directed byte streams.
`timescale 1ns / 1ps

module stx_frame_receiver_tb;
   import stx_pkg::*;

   localparam int SETTLE_CYCLES = 8;      // front + back stage, with margin
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 250;
   localparam int CYCLE_LIMIT   = 300000;

   logic       clock;
   logic       reset        = 1'b1;
   logic       req_push     = 1'b0;
   logic [7:0] req_rx_byte  = 8'h00;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop      = 1'b0;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_position;
   logic [7:0] rsp_frame_length;
   logic       csr_write_en = 1'b0;
   logic       csr_index    = CSR_NODE;
   logic [7:0] csr_wdata    = 8'h00;

   stx_frame_receiver DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_rx_byte       (req_rx_byte),
      .req_full          (req_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_length  (rsp_frame_length),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // pending line bytes and predicted events
   logic [7:0] pending[$];
   rsp_type    expected_events[$];
   int         items_queued   = 0;
   int         items_accepted = 0;
   int         errors         = 0;
   int         cycle_count    = 0;
   int         send_idle_pct  = 31;
   int         recv_idle_pct  = 67;
   logic       hold_armed     = 1'b0;
   logic       hold_used      = 1'b0;
   int         hold_left      = 0;

   // deframer shadow state
   mode_type   fr_mode   = MODE_IDLE;
   logic [7:0] fr_count  = 8'd0;
   logic [7:0] fr_length = 8'd0;
   logic [7:0] fr_sum    = 8'd0;
   logic [7:0] fr_node   = 8'd0;
   logic [7:0] fr_tag    = 8'd0;
   logic [7:0] cfg_node  = RESET_NODE;
   logic [7:0] cfg_tag   = RESET_TAG;

   // shift left, fold carry, add byte, fold carry
   function automatic logic [7:0] sum_step(input logic [7:0] acc, input logic [7:0] b);
      logic [9:0] c;
      c = {1'b0, acc, 1'b0};
      if (c[8]) c = {2'b00, c[7:0]} + 10'd1;
      c = c + {2'b00, b};
      if (c[8]) c = {2'b00, c[7:0]} + 10'd1;
      return c[7:0];
   endfunction

   task automatic note_event(input event_type kind, input logic [7:0] data,
                             input logic [7:0] pos, input logic [7:0] len);
      rsp_type ev;
      ev.kind = kind;
      ev.data = data;
      ev.pos  = pos;
      ev.len  = len;
      expected_events.push_back(ev);
   endtask

   task automatic open_frame(input logic [7:0] len);
      fr_length = len;
      fr_count  = POS_FIRST;
      fr_sum    = sum_step(sum_step(8'h00, BYTE_STX), len);
      fr_node   = 8'h00;
      fr_tag    = 8'h00;
      fr_mode   = MODE_FRAME;
      note_event(EV_START, len, POS_LENGTH, len);
   endtask

   task automatic take_frame_byte(input logic [7:0] b);
      logic [7:0] fin;
      bit         good;
      if (fr_count == POS_NODE) fr_node = b;
      if (fr_count == POS_TAG) fr_tag = b;
      fr_mode = MODE_FRAME;
      if ({1'b0, fr_count} + 9'd1 >= {1'b0, fr_length}) begin
         fin  = (fr_sum == BYTE_STX) ? STX_SUBST : fr_sum;
         good = (b == fin) && (fr_node == cfg_node) && (fr_tag == cfg_tag);
         fr_mode = MODE_IDLE;
         note_event(good ? EV_GOOD : EV_BAD, b, fr_count, fr_length);
      end else begin
         fr_sum = sum_step(fr_sum, b);
         note_event(EV_BYTE, b, fr_count, fr_length);
         fr_count = fr_count + 8'd1;
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      case (fr_mode)
         MODE_IDLE: begin
            if (b == BYTE_ACK) note_event(EV_ACK, BYTE_ACK, 8'd0, 8'd0);
            else if (b == BYTE_STX) fr_mode = MODE_LEN;
         end
         MODE_LEN: begin
            if (b < MIN_FRAME) fr_mode = MODE_IDLE;
            else open_frame(b);
         end
         MODE_FRAME: begin
            if (b == BYTE_STX) fr_mode = MODE_ESC;
            else take_frame_byte(b);
         end
         default: begin
            if (b == 8'd0) take_frame_byte(BYTE_STX);
            else if (b >= MIN_FRAME) open_frame(b);
            else begin
               fr_mode = MODE_IDLE;
               note_event(EV_ABORT, b, fr_count, fr_length);
            end
         end
      endcase
   endtask

   // sender: one word per accepted push
   always @(posedge clock) begin : byte_feed
      bit busy;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         busy = req_push;
         if (req_push && !req_full) begin
            deframe_byte(req_rx_byte);
            items_accepted = items_accepted + 1;
            busy = 1'b0;
         end
         if (!busy) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_rx_byte <= pending.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver: compare each popped word with the oldest prediction
   always @(posedge clock) begin : event_check
      rsp_type want;
      if (reset) begin
         rsp_pop   <= 1'b0;
         hold_used <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_events.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("unexpected word: kind %0d data %h pos %0d len %0d",
                           rsp_event_kind, rsp_data_byte, rsp_byte_position, rsp_frame_length);
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want.kind || rsp_data_byte !== want.data ||
                   rsp_byte_position !== want.pos || rsp_frame_length !== want.len) begin
                  errors = errors + 1;
                  if (errors <= 10) begin
                     $display("mismatch: expected kind %0d data %h pos %0d len %0d",
                              want.kind, want.data, want.pos, want.len);
                     $display("          got      kind %0d data %h pos %0d len %0d",
                              rsp_event_kind, rsp_data_byte, rsp_byte_position,
                              rsp_frame_length);
                  end
               end
            end
         end
         if (hold_armed && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_pop   <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      pending.push_back(b);
      items_queued = items_queued + 1;
   endtask

   // data byte 0x02 goes out stuffed
   task automatic send_byte(input logic [7:0] b);
      queue_byte(b);
      if (b == BYTE_STX) queue_byte(8'h00);
   endtask

   function automatic int pick_length();
      if ($urandom_range(49) == 0) return $urandom_range(17, 255);
      return $urandom_range(5, 16);
   endfunction

   task automatic queue_frame(input int len, input logic [7:0] node, input logic [7:0] tag,
                              input bit bad_sum, input bit stx_at3);
      logic [7:0] b;
      logic [7:0] sum;
      sum = sum_step(sum_step(8'h00, BYTE_STX), 8'(len));
      queue_byte(BYTE_STX);
      queue_byte(8'(len));
      for (int p = 2; p < len - 1; p++) begin
         if (p == POS_NODE) b = node;
         else if (p == POS_TAG) b = tag;
         else if ((stx_at3 && p == 3) || $urandom_range(9) == 0) b = BYTE_STX;
         else b = 8'($urandom_range(255));
         send_byte(b);
         sum = sum_step(sum, b);
      end
      if (sum == BYTE_STX) sum = STX_SUBST;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum);
   endtask

   // opening of a frame cut off before its checksum
   task automatic queue_partial();
      int len;
      int k;
      len = $urandom_range(5, 16);
      k   = $urandom_range(0, len - 3);
      queue_byte(BYTE_STX);
      queue_byte(8'(len));
      repeat (k) send_byte(8'($urandom_range(255)));
   endtask

   task automatic queue_random_traffic(input int count);
      int start;
      int sel;
      int flaw;
      start = items_queued;
      while (items_queued - start < count) begin
         sel = $urandom_range(99);
         if (sel < 55) begin
            queue_frame(pick_length(), cfg_node, cfg_tag, 1'b0, 1'b0);
         end else if (sel < 65) begin
            flaw = $urandom_range(2);
            queue_frame(pick_length(),
                        (flaw == 0) ? cfg_node ^ 8'($urandom_range(1, 255)) : cfg_node,
                        (flaw == 1) ? cfg_tag ^ 8'($urandom_range(1, 255)) : cfg_tag,
                        flaw == 2, 1'b0);
         end else if (sel < 72) begin
            queue_byte(BYTE_ACK);
         end else if (sel < 78) begin
            queue_byte(8'($urandom_range(255)));
         end else if (sel < 83) begin
            queue_byte(BYTE_STX);
            queue_byte(8'($urandom_range(0, 4)));
         end else if (sel < 90) begin
            queue_partial();
            queue_byte(BYTE_STX);
            queue_byte(8'($urandom_range(1, 4)));
         end else if (sel < 95) begin
            queue_partial();
            queue_frame(pick_length(), cfg_node, cfg_tag, 1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // drain everything, then close any frame left open so registers change while idle
   task automatic settle();
      while (1) begin
         while (items_accepted != items_queued || expected_events.size() != 0)
            @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (fr_mode == MODE_IDLE) break;
         case (fr_mode)
            MODE_LEN:   queue_byte(8'h00);
            MODE_FRAME: begin
               queue_byte(BYTE_STX);
               queue_byte(8'h01);
            end
            default:    queue_byte(8'h01);
         endcase
      end
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_NODE) cfg_node = value;
      else cfg_tag = value;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      queue_byte(BYTE_ACK);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(BYTE_STX);
      queue_byte(BYTE_STX);                 // short length, not taken as STX
      queue_byte(BYTE_ACK);
      queue_frame(7, cfg_node, cfg_tag, 1'b0, 1'b1);
      queue_byte(BYTE_STX);
      queue_byte(8'd6);
      queue_byte(cfg_node);
      queue_byte(BYTE_STX);
      queue_byte(8'd3);                     // abort
      queue_byte(BYTE_STX);
      queue_byte(8'd9);
      queue_frame(5, cfg_node, cfg_tag, 1'b0, 1'b0);   // restart inside a frame
      settle();

      write_reg(CSR_NODE, 8'h00);
      write_reg(CSR_TAG, 8'hFF);
      queue_random_traffic(PHASE_ITEMS);
      settle();

      send_idle_pct = 67;
      recv_idle_pct = 31;
      write_reg(CSR_NODE, 8'hFF);
      write_reg(CSR_TAG, 8'h00);
      queue_random_traffic(PHASE_ITEMS);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_NODE, 8'($urandom_range(255)));
      write_reg(CSR_TAG, 8'($urandom_range(255)));
      hold_armed <= 1'b1;
      queue_random_traffic(PHASE_ITEMS);
      settle();

      if (errors == 0 && expected_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* stx_frame_receiver.f */
+incdir+hdl
hdl/stx_pkg.sv
hdl/stx_fifo.sv
hdl/stx_front.sv
hdl/stx_back.sv
hdl/stx_frame_receiver.sv
tb/stx_frame_receiver_tb.sv
